// ===== rtl/aesp_pkg.sv =====
// Shared types and constants of the ANSI escape sequence parser.
package aesp_pkg;

	// Result kinds
	typedef enum logic [2:0] {
		K_PLAIN    = 3'd0,
		K_CSI_CTRL = 3'd1,
		K_CSI_DONE = 3'd2,
		K_OSC_DONE = 3'd3,
		K_ESC_DONE = 3'd4,
		K_PARAM    = 3'd5,
		K_BAD_CSI  = 3'd6,
		K_BAD_ESC  = 3'd7
	} kind_t;

	// Back-end drain sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SEND
	} bk_state_t;

	// Widest counts and addresses over the supported buffer depths
	localparam int PCNT_W  = 9;
	localparam int ICNT_W  = 4;
	localparam int PADDR_W = 8;
	localparam int CODE_W  = 21;

	// Command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// One command handed from the front end to the back end
	typedef struct packed {
		kind_t              kind;
		logic [CODE_W-1:0]  value;
		logic [CODE_W-1:0]  intro;
		logic [7:0]         flag;
		logic [PCNT_W-1:0]  pcount;
		logic [ICNT_W-1:0]  icount;
		logic [31:0]        ibytes;
		logic               ovf;
	} aesp_cmd_t;

	// Parameter store write port driven by the front end
	typedef struct packed {
		logic               en;
		logic [PADDR_W-1:0] addr;
		logic [CODE_W-1:0]  data;
	} aesp_wr_t;

	// Back-end status seen by the front end
	typedef struct packed {
		logic busy;
		logic drain_done;
	} aesp_bk_stat_t;

endpackage

// ===== rtl/aesp_front.sv =====
// Front end: accepts characters, classifies them and tracks sequence state.
module aesp_front #(
	parameter int PARAM_DEPTH = 32,
	parameter int INTER_DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [20:0]              char_code,
	input  logic                     q_full,
	output logic                     q_push,
	output aesp_pkg::aesp_cmd_t      q_cmd,
	output aesp_pkg::aesp_wr_t       wr,
	input  aesp_pkg::aesp_bk_stat_t  bk_stat
);
	import aesp_pkg::*;

	localparam int PCW    = $clog2(PARAM_DEPTH + 1);
	localparam int PAW    = $clog2(PARAM_DEPTH);
	localparam int ICW    = $clog2(INTER_DEPTH + 1);
	localparam int PACK_N = (INTER_DEPTH < 4) ? INTER_DEPTH : 4;

	typedef enum logic [2:0] {
		CL_CONTROL,
		CL_PARAM,
		CL_INTER,
		CL_ALPHA,
		CL_INVALID
	} cls_t;

	localparam logic [20:0] C_ESC     = 21'h1B;
	localparam logic [20:0] C_CSI     = 21'h5B;
	localparam logic [20:0] C_OSC     = 21'h5D;
	localparam logic [20:0] C_BEL     = 21'h07;
	localparam logic [20:0] C_ST      = 21'h9C;
	localparam logic [20:0] C_PRIV_LO = 21'h3C;
	localparam logic [20:0] C_PRIV_HI = 21'h3F;

	function automatic cls_t classify(input logic [20:0] c);
		cls_t r;
		if (c > 21'h9F) begin
			r = CL_INVALID;
		end else begin
			case (c[7:0]) inside
				[8'h00:8'h1F], [8'h7F:8'h9F]: r = CL_CONTROL;
				[8'h20:8'h2F]:                r = CL_INTER;
				[8'h30:8'h3F]:                r = CL_PARAM;
				default:                      r = CL_ALPHA;
			endcase
		end
		return r;
	endfunction

	logic              in_seq_q;
	logic              intro_valid_q;
	logic [20:0]       intro_q;
	logic [7:0]        flag_q;
	logic [PCW-1:0]    pfill_q;
	logic [ICW-1:0]    ifill_q;
	logic              ovf_q;
	logic              pend_q;
	logic [7:0]        inter_q [INTER_DEPTH];

	logic              accept;
	cls_t              cls;
	logic [20:0]       intro_now;
	logic [31:0]       packed_bytes;
	logic              open_seq;
	logic              take_intro;
	logic              flag_we;
	logic              p_add;
	logic              i_add;
	logic              fin;
	logic              fail;
	logic              emit;
	kind_t             ekind;
	logic [20:0]       eval;
	logic              p_room;
	logic              i_room;

	assign in_stall = q_full || pend_q;
	assign accept   = in_valid && !in_stall;
	assign p_room   = pfill_q < PCW'(PARAM_DEPTH);
	assign i_room   = ifill_q < ICW'(INTER_DEPTH);

	// Decode the accepted character against the current sequence state
	always_comb begin
		cls        = classify(char_code);
		intro_now  = intro_valid_q ? intro_q : char_code;
		open_seq   = 1'b0;
		take_intro = 1'b0;
		flag_we    = 1'b0;
		p_add      = 1'b0;
		i_add      = 1'b0;
		fin        = 1'b0;
		fail       = 1'b0;
		emit       = 1'b0;
		ekind      = K_PLAIN;
		eval       = char_code;
		if (accept) begin
			if (!in_seq_q) begin
				if (char_code == C_ESC) begin
					open_seq = 1'b1;
				end else begin
					emit  = 1'b1;
					ekind = K_PLAIN;
				end
			end else if (!intro_valid_q) begin
				take_intro = 1'b1;
				if (char_code == C_CSI || char_code == C_OSC) begin
					take_intro = 1'b1;
				end else if (cls == CL_INTER) begin
					i_add = 1'b1;
				end else if (cls == CL_INVALID) begin
					fail  = 1'b1;
					ekind = K_BAD_ESC;
				end else begin
					fin   = 1'b1;
					ekind = K_ESC_DONE;
					eval  = '0;
				end
			end else if (intro_q == C_CSI) begin
				case (cls)
					CL_PARAM: begin
						if (char_code >= C_PRIV_LO && char_code <= C_PRIV_HI) flag_we = 1'b1;
						else p_add = 1'b1;
					end
					CL_INTER: i_add = 1'b1;
					CL_ALPHA: begin
						fin   = 1'b1;
						ekind = K_CSI_DONE;
					end
					CL_CONTROL: begin
						emit  = 1'b1;
						ekind = K_CSI_CTRL;
					end
					default: begin
						fail  = 1'b1;
						ekind = K_BAD_CSI;
					end
				endcase
			end else if (intro_q == C_OSC) begin
				if (char_code == C_BEL || char_code == C_ST) begin
					fin   = 1'b1;
					ekind = K_OSC_DONE;
				end else begin
					p_add = 1'b1;
				end
			end else begin
				case (cls)
					CL_INTER: i_add = 1'b1;
					CL_PARAM, CL_ALPHA: begin
						fin   = 1'b1;
						ekind = K_ESC_DONE;
					end
					default: begin
						fail  = 1'b1;
						ekind = K_BAD_ESC;
					end
				endcase
			end
		end
	end

	// Pack kept intermediates, low byte first; unwritten slots read as zero
	always_comb begin
		packed_bytes = '0;
		for (int i = 0; i < PACK_N; i++) begin
			if (ifill_q > ICW'(i)) packed_bytes[8*i +: 8] = inter_q[i];
		end
	end

	// Build the queue command
	always_comb begin
		q_push = emit || fin || fail;
		q_cmd  = '0;
		q_cmd.kind  = ekind;
		q_cmd.value = eval;
		if (fin || fail) q_cmd.intro = intro_now;
		if (fin) begin
			q_cmd.flag   = (ekind == K_CSI_DONE) ? flag_q : 8'h00;
			q_cmd.pcount = PCNT_W'(pfill_q);
			q_cmd.icount = (ekind == K_OSC_DONE) ? '0 : ICNT_W'(ifill_q);
			q_cmd.ibytes = (ekind == K_OSC_DONE) ? '0 : packed_bytes;
			q_cmd.ovf    = ovf_q;
		end
	end

	assign wr.en   = p_add && p_room;
	assign wr.addr = PADDR_W'(pfill_q[PAW-1:0]);
	assign wr.data = char_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seq_q      <= 1'b0;
			intro_valid_q <= 1'b0;
			intro_q       <= '0;
			flag_q        <= '0;
			pfill_q       <= '0;
			ifill_q       <= '0;
			ovf_q         <= 1'b0;
		end else if (fin || fail) begin
			in_seq_q      <= 1'b0;
			intro_valid_q <= 1'b0;
			intro_q       <= '0;
			flag_q        <= '0;
			pfill_q       <= '0;
			ifill_q       <= '0;
			ovf_q         <= 1'b0;
		end else begin
			if (open_seq) in_seq_q <= 1'b1;
			if (take_intro) begin
				intro_valid_q <= 1'b1;
				intro_q       <= char_code;
			end
			if (flag_we) flag_q <= char_code[7:0];
			if (p_add) begin
				if (p_room) pfill_q <= pfill_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (i_add) begin
				if (i_room) ifill_q <= ifill_q + 1'b1;
				else ovf_q <= 1'b1;
			end
		end
	end

	// Hold input while a completed sequence's parameter bytes drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (fin && pfill_q != '0) begin
			pend_q <= 1'b1;
		end else if (bk_stat.drain_done) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < INTER_DEPTH; j++) begin
			if (i_add && i_room && ifill_q == ICW'(j)) inter_q[j] <= char_code[7:0];
		end
	end

endmodule

// ===== rtl/aesp_fifo.sv =====
// Short command queue between the parser front end and the result back end.
module aesp_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  aesp_pkg::aesp_cmd_t  din,
	output logic                 full,
	input  logic                 pop,
	output aesp_pkg::aesp_cmd_t  dout,
	output logic                 empty
);
	import aesp_pkg::*;

	aesp_cmd_t         mem_q [QDEPTH];
	logic [QAW-1:0]    wp_q;
	logic [QAW-1:0]    rp_q;
	logic [QAW:0]      cnt_q;

	assign full  = cnt_q == (QAW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

endmodule

// ===== rtl/aesp_back.sv =====
// Back end: emits headers and drains stored parameter bytes to the output.
module aesp_back #(
	parameter int PARAM_DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  aesp_pkg::aesp_cmd_t      q_cmd,
	output logic                     q_pop,
	input  aesp_pkg::aesp_wr_t       wr,
	output aesp_pkg::aesp_bk_stat_t  bk_stat,
	output logic                     out_valid,
	input  logic                     out_stall,
	output aesp_pkg::aesp_cmd_t      res,
	output logic                     res_last
);
	import aesp_pkg::*;

	localparam int PCW = $clog2(PARAM_DEPTH + 1);
	localparam int PAW = $clog2(PARAM_DEPTH);

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [PCW-1:0]    idx_q;
	logic [PCW-1:0]    cnt_q;
	logic [20:0]       mem_q [PARAM_DEPTH];
	logic [20:0]       rd_data_q;
	logic              out_valid_q;
	aesp_cmd_t         res_q;
	logic              last_q;

	logic              out_free;
	logic              drain;
	logic              rd_en;
	logic              load;
	logic              load_last;
	logic              idx_last;
	aesp_cmd_t         res_d;

	assign out_free = !out_valid_q || !out_stall;
	assign drain    = q_cmd.pcount != '0;
	assign idx_last = idx_q == cnt_q - 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (!q_empty && out_free && drain) state_d = BK_READ;
			BK_READ: state_d = BK_SEND;
			BK_SEND: if (out_free) state_d = idx_last ? BK_IDLE : BK_READ;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		rd_en      = 1'b0;
		load       = 1'b0;
		load_last  = 1'b0;
		res_d      = '0;
		bk_stat.drain_done = 1'b0;
		bk_stat.busy       = state_q != BK_IDLE;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop     = 1'b1;
					load      = 1'b1;
					load_last = !drain;
					res_d     = q_cmd;
				end
			end
			BK_READ: rd_en = 1'b1;
			BK_SEND: begin
				if (out_free) begin
					load        = 1'b1;
					load_last   = idx_last;
					res_d.kind  = K_PARAM;
					res_d.value = rd_data_q;
					bk_stat.drain_done = idx_last;
				end
			end
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && drain) begin
				idx_q <= '0;
				cnt_q <= PCW'(q_cmd.pcount);
			end else if (state_q == BK_SEND && out_free) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= res_d;
			last_q <= load_last;
		end
	end

	// Parameter store: written by the front end, read one byte per drain step
	always_ff @(posedge clk) begin
		if (wr.en) mem_q[wr.addr[PAW-1:0]] <= wr.data;
		if (rd_en) rd_data_q <= mem_q[idx_q[PAW-1:0]];
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign res_last  = last_q;

endmodule

// ===== rtl/ansi_escape_sequence_parser.sv =====
// Top level of the ANSI escape sequence parser.
// ECMA-48 escape sequence parser taking one character code per transaction.
// Plain characters pass through the command queue and the registered output
// stage and may follow each other every cycle while in_stall is low; an ESC,
// CSI, OSC or plain escape sequence is tracked by the front end, which writes
// up to PARAM_DEPTH parameter bytes into a memory in the back end and keeps
// INTER_DEPTH intermediate bytes in registers. A completed sequence yields a
// header result followed by its stored parameter bytes; each parameter byte
// is read from the memory and then loaded into the output. While those bytes
// drain the input is stalled, because the next sequence reuses the store. A
// four-entry command queue sits between the front and back ends, so plain
// characters keep flowing while the output side is stalled until it fills.
// The output is a registered stage: a new result loads whenever the current
// one is taken or the slot is empty. No clearing pass is needed after reset.
module ansi_escape_sequence_parser #(
	parameter int PARAM_DEPTH = 32,
	parameter int INTER_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [20:0]                         char_code,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          kind,
	output logic [20:0]                         value,
	output logic [20:0]                         intro_char,
	output logic [7:0]                          private_flag,
	output logic [$clog2(PARAM_DEPTH+1)-1:0]    param_count,
	output logic [$clog2(INTER_DEPTH+1)-1:0]    inter_count,
	output logic [31:0]                         inter_bytes,
	output logic                                overflow,
	output logic                                last
);
	import aesp_pkg::*;

	localparam int PCW = $clog2(PARAM_DEPTH + 1);
	localparam int ICW = $clog2(INTER_DEPTH + 1);

	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;
	aesp_cmd_t      q_in;
	aesp_cmd_t      q_out;
	aesp_wr_t       wr;
	aesp_bk_stat_t  bk_stat;
	aesp_cmd_t      res;
	logic           res_last;

	// Front end: classify each character and update sequence state
	aesp_front #(
		.PARAM_DEPTH(PARAM_DEPTH),
		.INTER_DEPTH(INTER_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.char_code(char_code),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_in),
		.wr       (wr),
		.bk_stat  (bk_stat)
	);

	// Decouple the two sides
	aesp_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_in),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_out),
		.empty (q_empty)
	);

	// Back end: emit headers and drain parameter bytes
	aesp_back #(
		.PARAM_DEPTH(PARAM_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_cmd    (q_out),
		.q_pop    (q_pop),
		.wr       (wr),
		.bk_stat  (bk_stat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res      (res),
		.res_last (res_last)
	);

	assign kind         = res.kind;
	assign value        = res.value;
	assign intro_char   = res.intro;
	assign private_flag = res.flag;
	assign param_count  = PCW'(res.pcount);
	assign inter_count  = ICW'(res.icount);
	assign inter_bytes  = res.ibytes;
	assign overflow     = res.ovf;
	assign last         = res_last;

	// The parameter store is never written while the back end drains it
	a_no_write_during_drain: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !bk_stat.busy)
		else $error("parameter store written during drain");

	// The final drained byte shows up as the closing result of its sequence
	a_drain_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.drain_done |=> out_valid && last && kind == K_PARAM)
		else $error("drain end not marked last");

	// The command queue is never pushed when full
	a_no_queue_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overrun");

endmodule
